/* rtl/sratoa_pkg.sv */
// sratoa_pkg: constants, status types and the digit-to-ASCII function
// shared by the signed radix to ASCII unit; no dependencies
package sratoa_pkg;

  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  // dividend bits retired per cycle by the digit divider
  localparam int STEP_BITS  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [DIGIT_W-1:0] DECIMAL_SPLIT = 4'd10;
  localparam logic [CHAR_W-1:0]  LETTER_BIAS   = 8'd55;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS   = 8'h2D;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DECIMAL_SPLIT) begin
      return ASCII_ZERO + d_ext;
    end
    return d_ext + LETTER_BIAS;
  endfunction

endpackage

/* rtl/sratoa_if.sv */
// sratoa_if: valid/ready channel interfaces for the number input and the
// character output; depends on sratoa_pkg for field widths
interface sratoa_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                               valid;
  logic                               ready;
  logic signed [VALUE_BITS-1:0]       value;
  logic [sratoa_pkg::RADIX_W-1:0]     radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface sratoa_out_if;
  logic                               valid;
  logic                               ready;
  logic [sratoa_pkg::CHAR_W-1:0]      char_code;
  logic                               last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/signed_radix_to_ascii_unit.sv */
// signed_radix_to_ascii_unit: the digits are produced by the single digit
// divider; the characters then leave one at a time.
// a two-entry queue lets new numbers be taken while one converts.
// synchronous active-low reset empties the queue and output; no clearing pass.
module signed_radix_to_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  sratoa_in_if.sink           in_ch,
  sratoa_out_if.source        out_ch
);

  localparam int ENTRY_W = VALUE_BITS + sratoa_pkg::RADIX_W + 1;

  logic                           q_full;
  logic                           q_push;
  logic                           q_pop;
  logic                           q_valid;
  logic                           f_negative;
  logic [sratoa_pkg::RADIX_W-1:0] f_radix;
  logic [VALUE_BITS-1:0]          f_magnitude;
  logic [ENTRY_W-1:0]             q_in;
  logic [ENTRY_W-1:0]             q_out;

  sratoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_value    (in_ch.value),
    .in_radix    (in_ch.radix),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_negative  (f_negative),
    .q_radix     (f_radix),
    .q_magnitude (f_magnitude)
  );

  assign q_in = {f_negative, f_radix, f_magnitude};

  sratoa_queue #(.WIDTH(ENTRY_W), .DEPTH(sratoa_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  sratoa_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_negative    (q_out[ENTRY_W-1]),
    .q_radix       (q_out[VALUE_BITS +: sratoa_pkg::RADIX_W]),
    .q_magnitude   (q_out[VALUE_BITS-1:0]),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last_char (out_ch.last_char)
  );

endmodule

/* rtl/sratoa_ram.sv */
// sratoa_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module sratoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sratoa_queue.sv */
// sratoa_queue: small flop-based fifo between the classify front and the
// conversion back end; no dependencies
module sratoa_queue #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

endmodule

/* rtl/sratoa_front.sv */
// sratoa_front: accepts numbers, clamps the radix and splits the value
// into sign and magnitude for the queue; depends on sratoa_pkg
module sratoa_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [VALUE_BITS-1:0]          in_value,
  input  logic [sratoa_pkg::RADIX_W-1:0] in_radix,
  input  logic                           q_full,
  output logic                           q_push,
  output logic                           q_negative,
  output logic [sratoa_pkg::RADIX_W-1:0] q_radix,
  output logic [VALUE_BITS-1:0]          q_magnitude
);

  logic negative;

  assign negative = in_value[VALUE_BITS-1];

  always_comb begin
    if (in_radix < sratoa_pkg::RADIX_MIN) begin
      q_radix = sratoa_pkg::RADIX_MIN;
    end else if (in_radix > sratoa_pkg::RADIX_MAX) begin
      q_radix = sratoa_pkg::RADIX_MAX;
    end else begin
      q_radix = in_radix;
    end
  end

  // most negative value wraps to itself, read as unsigned 2^(n-1)
  assign q_magnitude = negative ? (~in_value + VALUE_BITS'(1)) : in_value;
  assign q_negative  = negative;
  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;

endmodule

/* rtl/sratoa_divider.sv */
// sratoa_divider: iterative divide of a magnitude by a small radix,
// STEP_BITS quotient bits per cycle; depends on sratoa_pkg
module sratoa_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [sratoa_pkg::RADIX_W-1:0] radix,
  output sratoa_pkg::div_status_t        status,
  output logic [VALUE_BITS-1:0]          quotient
);

  localparam int STEP_BITS = sratoa_pkg::STEP_BITS;
  localparam int DIGIT_W   = sratoa_pkg::DIGIT_W;
  localparam int NSTEP     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W     = NSTEP * STEP_BITS;
  localparam int SW        = $clog2(NSTEP + 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(NSTEP - 1);

  logic [PAD_W-1:0]                 dq_r, dq_nxt;
  logic [DIGIT_W-1:0]               rem_r, rem_nxt;
  logic [sratoa_pkg::RADIX_W-1:0]   radix_r;
  logic [SW-1:0]                    step_r;
  logic                             run_r;
  logic                             done_r;

  // restoring division: remainder stays below the radix, so 5-bit compares
  always_comb begin
    logic [DIGIT_W:0]   trial;
    logic [DIGIT_W-1:0] rem_v;
    logic [PAD_W-1:0]   dq_v;
    rem_v = rem_r;
    dq_v  = dq_r;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_v, dq_v[PAD_W-1]};
      if (trial >= radix_r) begin
        trial = trial - radix_r;
        dq_v  = {dq_v[PAD_W-2:0], 1'b1};
      end else begin
        dq_v  = {dq_v[PAD_W-2:0], 1'b0};
      end
      rem_v = trial[DIGIT_W-1:0];
    end
    rem_nxt = rem_v;
    dq_nxt  = dq_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r && (step_r == LAST_STEP) && !start;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + SW'(1);
        if (step_r == LAST_STEP) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r    <= PAD_W'(dividend);
      rem_r   <= '0;
      radix_r <= radix;
    end else if (run_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign status.done = done_r;
  assign status.rem  = rem_r;
  assign quotient    = dq_r[VALUE_BITS-1:0];

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r)
    else $error("divider restarted while running");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < radix_r))
    else $error("digit not below radix");

endmodule

/* rtl/sratoa_back.sv */
// sratoa_back: digit sequencer; drives the divider, stacks digits in a ram
// and sends the text most significant first; needs sratoa_pkg, divider, ram
module sratoa_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  logic                                q_negative,
  input  logic [sratoa_pkg::RADIX_W-1:0]      q_radix,
  input  logic [VALUE_BITS-1:0]               q_magnitude,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sratoa_pkg::CHAR_W-1:0]       out_char_code,
  output logic                                out_last_char
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int AW    = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic                              neg_r, neg_nxt;
  logic [sratoa_pkg::RADIX_W-1:0]    radix_r, radix_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                  rd_dec;
  logic                              out_valid_r;
  logic [sratoa_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;
  logic                              out_load;
  logic                              slot_free;

  logic                              div_start;
  logic [VALUE_BITS-1:0]             div_dividend;
  logic [sratoa_pkg::RADIX_W-1:0]    div_radix;
  sratoa_pkg::div_status_t           div_st;
  logic [VALUE_BITS-1:0]             div_quot;

  logic                              ram_we;
  logic                              ram_re;
  logic [sratoa_pkg::DIGIT_W-1:0]    ram_rdata;

  sratoa_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (div_radix),
    .status   (div_st),
    .quotient (div_quot)
  );

  // digits land least significant first and are read back in reverse
  sratoa_ram #(.WIDTH(sratoa_pkg::DIGIT_W), .DEPTH(VALUE_BITS)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_st.rem),
    .re    (ram_re),
    .raddr (rd_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_dec    = cnt_r - CNT_W'(1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    neg_nxt      = neg_r;
    radix_nxt    = radix_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_radix    = radix_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    out_char_nxt = sratoa_pkg::digit_code(ram_rdata);
    out_last_nxt = (cnt_r == CNT_W'(1));
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          div_start    = 1'b1;
          div_dividend = q_magnitude;
          div_radix    = q_radix;
          neg_nxt      = q_negative;
          radix_nxt    = q_radix;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (div_quot == '0) begin
            state_nxt = neg_r ? S_SIGN : S_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = sratoa_pkg::ASCII_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          out_load  = 1'b1;
          cnt_nxt   = rd_dec;
          state_nxt = (cnt_r == CNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    radix_r <= radix_nxt;
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_BITS))
    else $error("digit count out of range");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("last character sent but sequencer still busy");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == sratoa_pkg::ASCII_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last character");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for signed_radix_to_ascii_unit, a directed table
// then random numbers, each character checked against typed text or a local
// text builder; depends on sratoa_pkg, sratoa_in_if/sratoa_out_if and the unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_ITEMS = 126;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int CHAR_W  = sratoa_pkg::CHAR_W;
  localparam int RADIX_W = sratoa_pkg::RADIX_W;
  localparam int DIGIT_W = sratoa_pkg::DIGIT_W;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } glyph_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]           radix;
    string                        text;
  } number_row_t;

  logic clk;
  logic rst_n;
  int   errors;
  int   quiet_cycles;

  glyph_t      expected_chars[$];
  number_row_t directed_rows[$];

  sratoa_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch();
  sratoa_out_if out_ch();

  signed_radix_to_ascii_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // queue the characters that one number should turn into
  function automatic void spell_number(input logic signed [VALUE_BITS-1:0] value,
                                       input logic [RADIX_W-1:0] radix);
    string                 glyphs;
    logic [VALUE_BITS-1:0] base;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    digits[VALUE_BITS];
    int                    ndig;
    glyph_t                g;
    glyphs = "0123456789ABCDEF";
    if (radix < sratoa_pkg::RADIX_MIN) begin
      base = VALUE_BITS'(sratoa_pkg::RADIX_MIN);
    end else if (radix > sratoa_pkg::RADIX_MAX) begin
      base = VALUE_BITS'(sratoa_pkg::RADIX_MAX);
    end else begin
      base = VALUE_BITS'(radix);
    end
    // unsigned negate keeps the most negative value whole
    mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    ndig = 0;
    do begin
      digits[ndig] = DIGIT_W'(mag % base);
      mag = mag / base;
      ndig++;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      g.char_code = sratoa_pkg::ASCII_MINUS;
      g.last_char = 1'b0;
      expected_chars.push_back(g);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      g.char_code = glyphs[digits[k]];
      g.last_char = (k == 0);
      expected_chars.push_back(g);
    end
  endfunction

  task automatic add_row(input logic signed [VALUE_BITS-1:0] value,
                         input int radix, input string text);
    number_row_t row;
    row.value = value;
    row.radix = RADIX_W'(radix);
    row.text  = text;
    directed_rows.push_back(row);
  endtask

  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  // one input transfer; typed text replaces the builder when given
  task automatic send_number(input logic signed [VALUE_BITS-1:0] value,
                             input logic [RADIX_W-1:0] radix, input string text,
                             input int gap, input bit drain);
    glyph_t g;
    if (drain) begin
      while (expected_chars.size() != 0) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.radix <= radix;
    do @(posedge clk); while (!in_ch.ready);
    if (text.len() == 0) begin
      spell_number(value, radix);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        g.char_code = text[i];
        g.last_char = (i == text.len() - 1);
        expected_chars.push_back(g);
      end
    end
  endtask

  task automatic take_chars();
    bit     calm;
    int     stall;
    glyph_t want;
    calm = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      stall = idle_cycles(calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual %h last %b",
                 $time, out_ch.char_code, out_ch.last_char);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.char_code !== want.char_code) begin
          $display("%0t: char_code mismatch: expected %h, actual %h",
                   $time, want.char_code, out_ch.char_code);
          errors++;
        end
        if (out_ch.last_char !== want.last_char) begin
          $display("%0t: last_char mismatch: expected %b, actual %b",
                   $time, want.last_char, out_ch.last_char);
          errors++;
        end
      end
    end
  endtask

  // ends the run if no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired, %0d chars outstanding", $time,
                 expected_chars.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]           radix;
    bit                           calm;
    errors       = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.radix  = '0;
    out_ch.ready = 1'b0;

    add_row(0, 10, "0");
    add_row(0, 2, "0");
    add_row(-1, 10, "-1");
    add_row(1, 2, "1");
    add_row(32'sh7FFFFFFF, 16, "7FFFFFFF");
    add_row(32'sh80000000, 16, "-80000000");
    add_row(32'sh7FFFFFFF, 10, "2147483647");
    add_row(32'sh80000000, 10, "-2147483648");
    add_row(32'sh80000000, 2, "");
    add_row(32'sh7FFFFFFF, 2, "");
    // radix out of range is clamped to 2 or 16
    add_row(5, 0, "101");
    add_row(2, 1, "10");
    add_row(255, 31, "FF");
    add_row(255, 17, "FF");
    add_row(15, 16, "F");
    add_row(10, 16, "A");
    add_row(9, 10, "9");
    add_row(16, 16, "10");
    add_row(-255, 16, "-FF");
    add_row(12345, 7, "");
    add_row(-98765, 3, "");
    add_row(32'shDEADBEEF, 16, "");
    add_row(1000, 9, "");
    add_row(32'sh55555555, 4, "");

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_chars();
    join_none

    calm = 1'b0;
    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].value, directed_rows[i].radix,
                  directed_rows[i].text, idle_cycles(calm), 1'b0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      case ($urandom_range(0, 5))
        0: value = $urandom_range(0, 40);
        1: value = -$signed(VALUE_BITS'($urandom_range(1, 40)));
        2: value = 32'sh80000000 + $urandom_range(0, 3);
        3: value = 32'sh7FFFFFFF - $urandom_range(0, 3);
        4: value = $signed(VALUE_BITS'($urandom_range(0, 65535))) - 32768;
        default: value = $urandom;
      endcase
      if ($urandom_range(0, 6) == 0) begin
        radix = RADIX_W'($urandom_range(0, 31));
      end else begin
        radix = RADIX_W'($urandom_range(2, 16));
      end
      // the first random number waits for the directed text to drain
      send_number(value, radix, "", idle_cycles(calm),
                  n == 0 || $urandom_range(0, 39) == 0);
    end
    in_ch.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sratoa_pkg.sv
rtl/sratoa_if.sv
rtl/sratoa_ram.sv
rtl/sratoa_queue.sv
rtl/sratoa_front.sv
rtl/sratoa_divider.sv
rtl/sratoa_back.sv
rtl/signed_radix_to_ascii_unit.sv
tb/tb_top.sv
